@@ src/kst_pkg.sv @@
// Package for the keyed slot table: field widths, operation codes and slot layout.
// No dependencies; imported by keyed_slot_table.
`timescale 1ns / 1ps
`default_nettype none

package kst_pkg;

  localparam int OP_W        = 3;
  localparam int KEY_W       = 31;
  localparam int ITEM_W      = 32;
  localparam int DEF_ENTRIES = 16;

  localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
  localparam logic [OP_W-1:0] OP_DEL_KEY = 3'd1;
  localparam logic [OP_W-1:0] OP_HAS     = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_VAL = 3'd3;
  localparam logic [OP_W-1:0] OP_START   = 3'd4;
  localparam logic [OP_W-1:0] OP_NEXT    = 3'd5;

  typedef struct packed {
    logic              vld;
    logic [KEY_W-1:0]  key;
    logic [ITEM_W-1:0] item;
  } slot_t;

endpackage

`default_nettype wire

@@ src/keyed_slot_table.sv @@
// Keyed slot table: fixed table of key/item slots held in one synchronous memory.
// Depends on kst_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Table of ENTRIES slots searched linearly from slot 0 (iterate next starts at
// the cursor). Each transaction walks the slot memory one entry per cycle with
// the reads pipelined; unused codes and an exhausted iterator skip the walk. A
// transaction is accepted in S_IDLE, walks in S_SCAN (stopping at the first
// matching slot) and loads the output register in S_DONE, where an output stall
// holds it; no new one is accepted until it ends. The single-port read of the
// slot memory paces the walk. Writes (add, delete) go back in the cycle the
// matching slot is seen. After reset the block sweeps the memory to clear every
// slot; no input transaction is accepted until it ends.
module keyed_slot_table #(
  parameter int ENTRIES = kst_pkg::DEF_ENTRIES
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [kst_pkg::OP_W-1:0]     operation_i,
  input  wire  [kst_pkg::KEY_W-1:0]    key_i,
  input  wire  [kst_pkg::ITEM_W-1:0]   item_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         found_o,
  output logic                         full_res_o,
  output logic [kst_pkg::ITEM_W-1:0]   item_out_o
);
  import kst_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] LAST_C = CW'(ENTRIES - 1);
  localparam logic [CW-1:0] END_C  = CW'(ENTRIES);
  localparam logic [AW-1:0] LAST_A = AW'(ENTRIES - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_DONE} state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       cursor_q, cursor_d;
  logic                chk_q, chk_d;
  logic [AW-1:0]       chk_idx_q, chk_idx_d;
  logic [OP_W-1:0]     op_q, op_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [ITEM_W-1:0]   item_q, item_d;
  logic                res_found_q, res_found_d;
  logic                res_full_q, res_full_d;
  logic [ITEM_W-1:0]   res_item_q, res_item_d;
  logic                out_valid_d, found_d, full_res_d;
  logic [ITEM_W-1:0]   item_out_d;

  slot_t               mem_q [ENTRIES];
  slot_t               rd_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_wa, mem_ra;
  slot_t               mem_wd;
  logic                hit, stop;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_ra];
    end
  end

  // match test on the slot read in the previous cycle
  always_comb begin
    case (op_q)
      OP_ADD:     hit = !rd_q.vld;
      OP_DEL_KEY: hit = rd_q.vld && (rd_q.key == key_q);
      OP_HAS:     hit = rd_q.vld && (rd_q.key == key_q);
      OP_DEL_VAL: hit = rd_q.vld && (rd_q.item == item_q);
      OP_START:   hit = rd_q.vld;
      OP_NEXT:    hit = rd_q.vld;
      default:    hit = 1'b0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cursor_d    = cursor_q;
    chk_d       = 1'b0;
    chk_idx_d   = chk_idx_q;
    op_d        = op_q;
    key_d       = key_q;
    item_d      = item_q;
    res_found_d = res_found_q;
    res_full_d  = res_full_q;
    res_item_d  = res_item_q;
    out_valid_d = out_valid_o && out_stall_i;
    found_d     = found_o;
    full_res_d  = full_res_o;
    item_out_d  = item_out_o;
    mem_we      = 1'b0;
    mem_wa      = chk_idx_q;
    mem_wd      = '0;
    mem_re      = 1'b0;
    mem_ra      = idx_q[AW-1:0];
    stop        = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = idx_q[AW-1:0];
        if (idx_q == LAST_C) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d        = operation_i;
          key_d       = key_i;
          item_d      = item_i;
          res_found_d = 1'b0;
          res_full_d  = 1'b0;
          res_item_d  = '0;
          idx_d       = (operation_i == OP_NEXT) ? cursor_q : '0;
          if (operation_i == OP_START) begin
            cursor_d = '0;
          end
          // unused codes and an exhausted iterator need no walk
          if ((operation_i != OP_ADD) && (operation_i != OP_DEL_KEY) &&
              (operation_i != OP_HAS) && (operation_i != OP_DEL_VAL) &&
              (operation_i != OP_START) && (operation_i != OP_NEXT)) begin
            state_d = S_DONE;
          end else if ((operation_i == OP_NEXT) && (cursor_q == END_C)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (chk_q) begin
          if (hit) begin
            stop        = 1'b1;
            res_found_d = (op_q != OP_ADD);
            if (op_q == OP_ADD) begin
              mem_we = 1'b1;
              mem_wd = '{vld: 1'b1, key: key_q, item: item_q};
            end else if ((op_q == OP_DEL_KEY) || (op_q == OP_DEL_VAL)) begin
              mem_we = 1'b1;
              mem_wd = '{vld: 1'b0, key: rd_q.key, item: rd_q.item};
            end else if (op_q == OP_NEXT) begin
              res_item_d = rd_q.item;
              cursor_d   = CW'(chk_idx_q) + CW'(1);
            end
          end else if (chk_idx_q == LAST_A) begin
            stop       = 1'b1;
            res_full_d = (op_q == OP_ADD);
          end
        end
        if (stop) begin
          state_d = S_DONE;
        end else if (idx_q < END_C) begin
          mem_re    = 1'b1;
          idx_d     = idx_q + CW'(1);
          chk_d     = 1'b1;
          chk_idx_d = idx_q[AW-1:0];
        end
      end
      S_DONE: begin
        if (!out_valid_o || !out_stall_i) begin
          out_valid_d = 1'b1;
          found_d     = res_found_q;
          full_res_d  = res_full_q;
          item_out_d  = res_item_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      cursor_q    <= '0;
      chk_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cursor_q    <= cursor_d;
      chk_q       <= chk_d;
      out_valid_o <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q   <= chk_idx_d;
    op_q        <= op_d;
    key_q       <= key_d;
    item_q      <= item_d;
    res_found_q <= res_found_d;
    res_full_q  <= res_full_d;
    res_item_q  <= res_item_d;
    found_o     <= found_d;
    full_res_o  <= full_res_d;
    item_out_o  <= item_out_d;
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(full_res_o && found_o))
    else $error("full and found reported together");

  a_item_needs_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (item_out_o != '0)) |-> found_o)
    else $error("item returned without found");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= END_C)
    else $error("scan cursor beyond table");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("slot memory written while idle");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second transaction taken before the first completed");

endmodule

`default_nettype wire
